// ===== sv/dtc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dtc_pkg - decimating trace capture shared definitions
// Transfer types, item kinds, capture modes and sizing defaults.
// ---------------------------------------------------------------------------
package dtc_pkg;

    // Sizing defaults
    localparam int unsigned BUFFER_WORDS = 16384;
    localparam int unsigned MAX_CHANNELS = 10;
    localparam int unsigned SAMPLE_BITS  = 32;

    // Field widths of the transfers
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned ROW_FIELD_W = 14;
    localparam int unsigned ROWS_W      = 15;
    localparam int unsigned CHAN_W      = 4;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned RATE_W      = 16;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GRAB   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WATCH  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LIVE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HALT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

    // Capture modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_GRAB  = 2'd1;
    localparam logic [1:0] MODE_WATCH = 2'd2;
    localparam logic [1:0] MODE_LIVE  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_DECIMATION_RATE = 1'b0;
    localparam logic CFG_CHANNELS_IN_USE = 1'b1;

    // Register reset values
    localparam logic [RATE_W-1:0] RESET_RATE     = 16'd5;
    localparam logic [CHAN_W-1:0] RESET_CHANNELS = 4'd10;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [SAMPLE_BITS-1:0] sample_value;
        logic                   sample_last;
        logic                   fault;
        logic [ROW_FIELD_W-1:0] read_row;
        logic [CHAN_W-1:0]      read_channel;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] read_data;
        logic [1:0]             mode_now;
        logic [ROW_FIELD_W-1:0] current_row;
        logic [ROWS_W-1:0]      row_count;
        logic [COUNT_W-1:0]     tick_count;
    } t_out_item;

endpackage
`default_nettype wire

// ===== sv/decimating_trace_capture.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// decimating_trace_capture - decimating trace capture into a ring buffer
// Stores one row of channel samples per decimation period, runs grab, watch
// and live capture modes and answers word reads from the buffer.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ---------------------------
//  in        in         i_in_valid / o_in_stall     i_in_data  (t_in_item)
//  out       out        o_out_valid / i_out_stall   o_out_data (t_out_item)
//  cfg       in         i_cfg_we                    i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while the output is not stalled; state
//  updates and the buffer write take place at the transfer edge, the result
//  follows through the buffer read register and the output register.
//  The rate is set by the buffer's single write port and single read port.
//  Reset clears all control state; the buffer itself is not cleared.
//  A stall on the output holds the output register; the read stage still
//  takes one more item before the input stalls.
//
module decimating_trace_capture #(
    parameter int unsigned BUFFER_WORDS = dtc_pkg::BUFFER_WORDS,
    parameter int unsigned MAX_CHANNELS = dtc_pkg::MAX_CHANNELS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  dtc_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output dtc_pkg::t_out_item               o_out_data,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_index,
    input  wire [dtc_pkg::RATE_W-1:0]        i_cfg_data
);

    localparam int unsigned RW  = $clog2(BUFFER_WORDS);
    localparam int unsigned AW  = $clog2(BUFFER_WORDS);
    localparam int unsigned CW  = $clog2(MAX_CHANNELS + 1);
    localparam int unsigned WPW = RW + CW + 1;
    localparam int unsigned RRW = (RW > dtc_pkg::ROW_FIELD_W) ? RW : dtc_pkg::ROW_FIELD_W;
    localparam int unsigned RPW = RRW + CW + 1;
    localparam int unsigned SW  = dtc_pkg::SAMPLE_BITS;
    localparam int unsigned RST_CHANNELS =
        (int'(dtc_pkg::RESET_CHANNELS) > MAX_CHANNELS) ? MAX_CHANNELS
                                                       : int'(dtc_pkg::RESET_CHANNELS);
    localparam int unsigned RST_ROWS = BUFFER_WORDS / RST_CHANNELS;

    // Configuration registers
    logic [dtc_pkg::RATE_W-1:0] r_cfg_rate;
    logic [dtc_pkg::CHAN_W-1:0] r_cfg_chan;

    // Capture state
    logic [1:0]                  r_mode,   n_mode;
    logic [dtc_pkg::RATE_W-1:0]  r_skip,   n_skip;
    logic [dtc_pkg::COUNT_W-1:0] r_period, n_period;
    logic [RW-1:0]               r_wrow,   n_wrow;
    logic [CW-1:0]               r_chpos,  n_chpos;
    logic [RW:0]                 r_rows,   n_rows;
    logic [dtc_pkg::RATE_W-1:0]  r_lrate,  n_lrate;
    logic [CW-1:0]               r_lchan,  n_lchan;

    // Pipeline registers
    logic                   r_s1_valid;
    logic                   r_s1_rd_ok;
    dtc_pkg::t_out_item     r_s1_status;
    logic [SW-1:0]          r_mem_q;
    logic                   r_out_valid;
    dtc_pkg::t_out_item     r_out;

    // Trace buffer
    logic [SW-1:0] r_mem [BUFFER_WORDS];

    logic                   w_accept;
    logic                   w_out_load;
    logic                   w_s1_move;
    logic [RW:0]            w_quot [1:MAX_CHANNELS];
    logic [CW-1:0]          w_start_chan;
    logic [dtc_pkg::RATE_W:0] w_skip_inc;
    logic [dtc_pkg::COUNT_W-1:0] w_period_inc;
    logic [WPW-1:0]         w_wr_prod;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [RPW-1:0]         w_rd_prod;
    logic                   w_rd_ok;
    logic [AW-1:0]          w_raddr;
    dtc_pkg::t_out_item     w_status;
    dtc_pkg::t_out_item     w_out_next;

    // Rows per channel count, worked out at elaboration
    for (genvar g = 1; g <= MAX_CHANNELS; g++) begin : g_quot
        localparam int unsigned QUOT = BUFFER_WORDS / g;
        assign w_quot[g] = (RW + 1)'(QUOT);
    end

    // Handshake: the read stage frees up whenever it can move on
    assign w_out_load  = !r_out_valid || !i_out_stall;
    assign w_s1_move   = r_s1_valid && w_out_load;
    assign o_in_stall  = r_s1_valid && !w_out_load;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Clamp the channel setting taken at start
    always_comb begin
        if (r_cfg_chan == '0) begin
            w_start_chan = CW'(1);
        end else if (int'(r_cfg_chan) > MAX_CHANNELS) begin
            w_start_chan = CW'(MAX_CHANNELS);
        end else begin
            w_start_chan = CW'(r_cfg_chan);
        end
    end

    // Write address of the current sample within the current row
    assign w_wr_prod = WPW'(r_wrow) * WPW'(r_lchan) + WPW'(r_chpos);
    assign w_waddr   = w_wr_prod[AW-1:0];

    // Read address and range check
    assign w_rd_prod = RPW'(i_in_data.read_row) * RPW'(r_lchan)
                     + RPW'(i_in_data.read_channel);
    assign w_raddr   = w_rd_prod[AW-1:0];
    assign w_rd_ok   = (i_in_data.kind == dtc_pkg::KIND_READ)
                    && ((RRW + 1)'(i_in_data.read_row) < (RRW + 1)'(r_rows))
                    && (32'(i_in_data.read_channel) < 32'(r_lchan))
                    && (w_rd_prod < RPW'(BUFFER_WORDS));

    assign w_skip_inc   = (dtc_pkg::RATE_W + 1)'(r_skip) + 1'b1;
    assign w_period_inc = r_period + 1'b1;

    // Next capture state for the item in transfer
    always_comb begin
        n_mode   = r_mode;
        n_skip   = r_skip;
        n_period = r_period;
        n_wrow   = r_wrow;
        n_chpos  = r_chpos;
        n_rows   = r_rows;
        n_lrate  = r_lrate;
        n_lchan  = r_lchan;
        w_we     = 1'b0;
        case (i_in_data.kind) inside
            dtc_pkg::KIND_SAMPLE: begin
                if (r_mode != dtc_pkg::MODE_OFF) begin
                    w_we = (r_skip == '0) && (r_chpos < r_lchan)
                        && (w_wr_prod < WPW'(BUFFER_WORDS));
                    if (r_chpos < r_lchan) begin
                        n_chpos = r_chpos + 1'b1;
                    end
                    if (i_in_data.sample_last) begin
                        n_chpos = '0;
                        if (w_skip_inc >= (dtc_pkg::RATE_W + 1)'(r_lrate)) begin
                            n_skip   = '0;
                            n_period = w_period_inc;
                            n_wrow   = ((RW + 1)'(r_wrow) + 1'b1 < r_rows)
                                     ? r_wrow + 1'b1 : '0;
                            if (r_mode == dtc_pkg::MODE_GRAB &&
                                w_period_inc >= dtc_pkg::COUNT_W'(r_rows)) begin
                                n_mode = dtc_pkg::MODE_OFF;
                            end
                            if (r_mode == dtc_pkg::MODE_WATCH && i_in_data.fault) begin
                                n_mode = dtc_pkg::MODE_OFF;
                            end
                        end else begin
                            n_skip = w_skip_inc[dtc_pkg::RATE_W-1:0];
                        end
                    end
                end
            end
            dtc_pkg::KIND_GRAB, dtc_pkg::KIND_WATCH, dtc_pkg::KIND_LIVE: begin
                n_lchan  = w_start_chan;
                n_rows   = w_quot[w_start_chan];
                n_lrate  = (r_cfg_rate == '0) ? dtc_pkg::RATE_W'(1) : r_cfg_rate;
                n_period = '0;
                n_skip   = '0;
                n_chpos  = '0;
                if ((RW + 1)'(r_wrow) >= w_quot[w_start_chan]) begin
                    n_wrow = '0;
                end
                n_mode = i_in_data.kind[1:0];
            end
            dtc_pkg::KIND_HALT: begin
                n_mode = dtc_pkg::MODE_OFF;
            end
            default: begin
            end
        endcase
    end

    // Status reported with the result
    always_comb begin
        w_status.read_data   = '0;
        w_status.mode_now    = n_mode;
        w_status.current_row = dtc_pkg::ROW_FIELD_W'(n_wrow);
        w_status.row_count   = dtc_pkg::ROWS_W'(n_rows);
        w_status.tick_count  = n_period;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rate <= dtc_pkg::RESET_RATE;
            r_cfg_chan <= dtc_pkg::RESET_CHANNELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dtc_pkg::CFG_DECIMATION_RATE: r_cfg_rate <= i_cfg_data;
                dtc_pkg::CFG_CHANNELS_IN_USE: r_cfg_chan <= i_cfg_data[dtc_pkg::CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance capture state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= dtc_pkg::MODE_OFF;
            r_skip   <= '0;
            r_period <= '0;
            r_wrow   <= '0;
            r_chpos  <= '0;
            r_rows   <= (RW + 1)'(RST_ROWS);
            r_lrate  <= dtc_pkg::RESET_RATE;
            r_lchan  <= CW'(RST_CHANNELS);
        end else if (w_accept) begin
            r_mode   <= n_mode;
            r_skip   <= n_skip;
            r_period <= n_period;
            r_wrow   <= n_wrow;
            r_chpos  <= n_chpos;
            r_rows   <= n_rows;
            r_lrate  <= n_lrate;
            r_lchan  <= n_lchan;
        end
    end

    // Buffer write port
    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) begin
            r_mem[w_waddr] <= i_in_data.sample_value;
        end
    end

    // Buffer read port; hold the word while the read stage waits
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem_q <= r_mem[w_raddr];
        end
    end

    // Read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_rd_ok  <= w_rd_ok;
            r_s1_status <= w_status;
        end
    end

    // Merge the read word into the status
    always_comb begin
        w_out_next           = r_s1_status;
        w_out_next.read_data = r_s1_rd_ok ? r_mem_q : '0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out <= w_out_next;
        end
    end

    // Capture state invariants
    a_lchan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lchan != '0) && (int'(r_lchan) <= MAX_CHANNELS))
        else $error("latched channel count out of range");

    a_wrow_below_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (RW + 1)'(r_wrow) < r_rows)
        else $error("write row not below rows in use");

    a_chpos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chpos <= r_lchan)
        else $error("channel position beyond channel count");

    a_skip_below_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip < r_lrate)
        else $error("skip count reached latched rate");

    a_write_needs_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_we) |-> (r_mode != dtc_pkg::MODE_OFF))
        else $error("buffer write while capture disabled");

    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while both result stages are full");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top - testbench for the decimating trace capture engine
// Drives sample, start, halt and read items with random gaps, stalls the
// status output at random and checks every status word against an in-bench
// model of the capture state and the row buffer. Runs through several
// register settings and a grab run at the smallest row count that takes a
// full buffer of rows, wraps the row index and stops.
// ---------------------------------------------------------------------------
module tb_top;

    // Kinds the block ignores
    localparam logic [dtc_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [dtc_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    wire                         in_stall;
    dtc_pkg::t_in_item           in_data = '0;
    wire                         out_valid;
    logic                        out_stall = 1'b0;
    dtc_pkg::t_out_item          out_data;
    logic                        cfg_we = 1'b0;
    logic                        cfg_index = 1'b0;
    logic [dtc_pkg::RATE_W-1:0]  cfg_data = '0;

    // Model of the engine
    logic [dtc_pkg::RATE_W-1:0]      reg_rate = dtc_pkg::RESET_RATE;
    logic [dtc_pkg::CHAN_W-1:0]      reg_chan = dtc_pkg::RESET_CHANNELS;
    logic [1:0]                      cap_mode = dtc_pkg::MODE_OFF;
    int unsigned                     skip = 0;
    logic [dtc_pkg::COUNT_W-1:0]     periods = '0;
    int unsigned                     wrow = 0;
    int unsigned                     chpos = 0;
    int unsigned                     rows = dtc_pkg::BUFFER_WORDS / dtc_pkg::MAX_CHANNELS;
    int unsigned                     lat_rate = dtc_pkg::RESET_RATE;
    int unsigned                     lat_ch = dtc_pkg::MAX_CHANNELS;
    int unsigned                     last_row = dtc_pkg::BUFFER_WORDS;
    logic [dtc_pkg::SAMPLE_BITS-1:0] trace_words [dtc_pkg::BUFFER_WORDS];
    bit                              word_valid [dtc_pkg::BUFFER_WORDS];

    dtc_pkg::t_in_item    pending_items[$];
    dtc_pkg::t_out_item   status_due[$];
    int unsigned n_sent = 0;
    int unsigned n_taken = 0;
    int unsigned n_done = 0;
    int unsigned n_bad = 0;
    int unsigned in_gap = 0;
    int unsigned out_hold = 0;
    bit          in_steady = 1'b0;
    bit          out_steady = 1'b0;

    decimating_trace_capture DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Advance the model by one item and return the status it reports
    function automatic dtc_pkg::t_out_item capture_status(input dtc_pkg::t_in_item it);
        dtc_pkg::t_out_item res;
        int unsigned        addr;
        res = '0;
        case (it.kind) inside
            dtc_pkg::KIND_SAMPLE: begin
                if (cap_mode != dtc_pkg::MODE_OFF) begin
                    // store only on the first tick of a period, drop surplus words
                    if (skip == 0 && chpos < lat_ch) begin
                        addr = wrow * lat_ch + chpos;
                        if (addr < dtc_pkg::BUFFER_WORDS) begin
                            trace_words[addr] = it.sample_value;
                            word_valid[addr] = 1'b1;
                            last_row = wrow;
                        end
                    end
                    if (chpos < lat_ch)
                        chpos++;
                    if (it.sample_last) begin
                        chpos = 0;
                        skip++;
                        if (skip >= lat_rate) begin
                            periods++;
                            skip = 0;
                            wrow = (wrow + 1 < rows) ? wrow + 1 : 0;
                            if (cap_mode == dtc_pkg::MODE_GRAB && periods >= rows)
                                cap_mode = dtc_pkg::MODE_OFF;
                            else if (cap_mode == dtc_pkg::MODE_WATCH && it.fault)
                                cap_mode = dtc_pkg::MODE_OFF;
                        end
                    end
                end
            end
            dtc_pkg::KIND_GRAB, dtc_pkg::KIND_WATCH, dtc_pkg::KIND_LIVE: begin
                // latch registers, clamp the channel count, clear the counts
                lat_ch = (reg_chan == 0) ? 1
                       : (reg_chan > dtc_pkg::MAX_CHANNELS) ? dtc_pkg::MAX_CHANNELS
                       : reg_chan;
                rows = dtc_pkg::BUFFER_WORDS / lat_ch;
                lat_rate = (reg_rate == 0) ? 1 : reg_rate;
                periods = '0;
                skip = 0;
                chpos = 0;
                if (wrow >= rows)
                    wrow = 0;
                cap_mode = (it.kind == dtc_pkg::KIND_GRAB) ? dtc_pkg::MODE_GRAB
                         : (it.kind == dtc_pkg::KIND_WATCH) ? dtc_pkg::MODE_WATCH
                         : dtc_pkg::MODE_LIVE;
            end
            dtc_pkg::KIND_HALT: begin
                cap_mode = dtc_pkg::MODE_OFF;
            end
            dtc_pkg::KIND_READ: begin
                if (it.read_row < rows && it.read_channel < lat_ch) begin
                    addr = it.read_row * lat_ch + it.read_channel;
                    if (addr < dtc_pkg::BUFFER_WORDS)
                        res.read_data = trace_words[addr];
                end
            end
            default: begin
            end
        endcase
        res.mode_now = cap_mode;
        res.current_row = dtc_pkg::ROW_FIELD_W'(wrow);
        res.row_count = dtc_pkg::ROWS_W'(rows);
        res.tick_count = periods;
        return res;
    endfunction

    function automatic dtc_pkg::t_in_item random_item(input logic [dtc_pkg::KIND_W-1:0] k);
        dtc_pkg::t_in_item it;
        it.kind = k;
        it.sample_value = $urandom;
        it.sample_last = 1'($urandom_range(0, 1));
        it.fault = 1'($urandom_range(0, 1));
        it.read_row = dtc_pkg::ROW_FIELD_W'($urandom_range(0, (1 << dtc_pkg::ROW_FIELD_W) - 1));
        it.read_channel = dtc_pkg::CHAN_W'($urandom_range(0, (1 << dtc_pkg::CHAN_W) - 1));
        return it;
    endfunction

    function automatic dtc_pkg::t_in_item sample_item(
        input logic [dtc_pkg::SAMPLE_BITS-1:0] value, input bit last, input bit flt);
        dtc_pkg::t_in_item it;
        it = random_item(dtc_pkg::KIND_SAMPLE);
        it.sample_value = value;
        it.sample_last = last;
        it.fault = flt;
        return it;
    endfunction

    function automatic dtc_pkg::t_in_item read_at(input int unsigned row,
                                                  input int unsigned ch);
        dtc_pkg::t_in_item it;
        it = random_item(dtc_pkg::KIND_READ);
        it.read_row = dtc_pkg::ROW_FIELD_W'(row);
        it.read_channel = dtc_pkg::CHAN_W'(ch);
        return it;
    endfunction

    // Pick a written word, mostly near the newest row; else read out of range
    function automatic dtc_pkg::t_in_item read_item();
        dtc_pkg::t_in_item it;
        int unsigned       r, c, k;
        bit                hit;
        it = random_item(dtc_pkg::KIND_READ);
        hit = 1'b0;
        if ($urandom_range(0, 7) != 0) begin
            for (k = 0; k < 12 && !hit; k++) begin
                if ((k % 2) == 0 && last_row < rows)
                    r = (last_row + rows - $urandom_range(0, 3)) % rows;
                else
                    r = $urandom_range(0, rows - 1);
                c = $urandom_range(0, lat_ch - 1);
                hit = word_valid[r * lat_ch + c];
            end
        end
        if (hit) begin
            it.read_row = dtc_pkg::ROW_FIELD_W'(r);
            it.read_channel = dtc_pkg::CHAN_W'(c);
        end else if (rows < dtc_pkg::BUFFER_WORDS && $urandom_range(0, 1)) begin
            it.read_row = dtc_pkg::ROW_FIELD_W'($urandom_range(rows,
                                                               dtc_pkg::BUFFER_WORDS - 1));
        end else begin
            it.read_channel = dtc_pkg::CHAN_W'($urandom_range(lat_ch,
                                                              (1 << dtc_pkg::CHAN_W) - 1));
        end
        return it;
    endfunction

    function automatic logic [dtc_pkg::KIND_W-1:0] pick_start();
        case ($urandom_range(0, 2))
            0: return dtc_pkg::KIND_GRAB;
            1: return dtc_pkg::KIND_WATCH;
            default: return dtc_pkg::KIND_LIVE;
        endcase
    endfunction

    // Mostly full ticks, some short, some with surplus samples
    function automatic int unsigned tick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return lat_ch;
        if (r < 85)
            return $urandom_range(1, lat_ch);
        return lat_ch + $urandom_range(1, 3);
    endfunction

    task automatic send(input dtc_pkg::t_in_item it);
        status_due.push_back(capture_status(it));
        pending_items.push_back(it);
        n_sent++;
    endtask

    task automatic send_tick(input int unsigned count, input bit fault_flag);
        dtc_pkg::t_in_item it;
        int unsigned       i;
        for (i = 0; i < count; i++) begin
            it = random_item(dtc_pkg::KIND_SAMPLE);
            it.sample_last = (i == count - 1);
            if (it.sample_last)
                it.fault = fault_flag;
            send(it);
        end
    endtask

    // Wait for every status word, then let the pipeline drain
    task automatic settle(input int unsigned extra);
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_regs(input logic [dtc_pkg::RATE_W-1:0] rate,
                            input logic [dtc_pkg::CHAN_W-1:0] chan);
        settle(4);
        cfg_we <= 1'b1;
        cfg_index <= dtc_pkg::CFG_DECIMATION_RATE;
        cfg_data <= rate;
        @(posedge clk);
        cfg_index <= dtc_pkg::CFG_CHANNELS_IN_USE;
        cfg_data <= dtc_pkg::RATE_W'(chan);
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_rate = rate;
        reg_chan = chan;
    endtask

    // Start a capture, then mix ticks, reads, restarts, halts and ignored kinds
    task automatic run_phase(input int unsigned n_items);
        int unsigned stop_at, r;
        stop_at = n_sent + n_items;
        send(random_item(pick_start()));
        while (n_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (cap_mode == dtc_pkg::MODE_OFF && r < 50)
                send(random_item(pick_start()));
            else if (r < 66)
                send_tick(tick_len(), (cap_mode == dtc_pkg::MODE_WATCH)
                                      ? ($urandom_range(0, 5) == 0)
                                      : 1'($urandom_range(0, 1)));
            else if (r < 84)
                send(read_item());
            else if (r < 88)
                send(random_item(pick_start()));
            else if (r < 91)
                send(random_item(dtc_pkg::KIND_HALT));
            else if (r < 94)
                send(random_item($urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7));
            else
                send(random_item(dtc_pkg::KIND_SAMPLE));
        end
    endtask

    // One uninterrupted grab of one-sample ticks up to its stop, with occasional reads
    task automatic run_grab();
        send(random_item(dtc_pkg::KIND_GRAB));
        while (cap_mode != dtc_pkg::MODE_OFF) begin
            if ($urandom_range(0, 63) == 0)
                send(read_item());
            else
                send_tick(1, 1'($urandom_range(0, 1)));
        end
    endtask

    // Stimulus and end of run
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_regs(16'd2, 4'd2);
        send(read_at(16383, 15));
        send(sample_item('1, 1'b1, 1'b1));
        send(random_item(KIND_SPARE6));
        send(random_item(KIND_SPARE7));
        send(random_item(dtc_pkg::KIND_HALT));
        send(random_item(dtc_pkg::KIND_GRAB));
        send(sample_item('1, 1'b0, 1'b0));
        send(sample_item('0, 1'b0, 1'b0));
        send(sample_item(32'hA5A5_A5A5, 1'b1, 1'b0));
        send(sample_item(32'h1234_5678, 1'b1, 1'b1));
        send(sample_item(32'hDEAD_BEEF, 1'b1, 1'b0));
        send(read_at(0, 0));
        send(read_at(0, 1));
        send(read_at(1, 0));
        send(read_at(0, 2));
        send(sample_item(32'h1, 1'b0, 1'b0));
        send(random_item(dtc_pkg::KIND_WATCH));
        send(sample_item(32'h2, 1'b1, 1'b1));
        send(sample_item(32'h3, 1'b1, 1'b1));
        send(sample_item(32'h4, 1'b1, 1'b0));
        send(random_item(dtc_pkg::KIND_LIVE));
        send(read_at(1, 0));
        send(random_item(dtc_pkg::KIND_HALT));
        send(read_at(9000, 0));

        set_regs(dtc_pkg::RESET_RATE, dtc_pkg::RESET_CHANNELS);
        run_phase(25);
        set_regs(16'd1, 4'd1);
        run_phase(25);
        set_regs(16'd0, 4'd3);
        run_phase(25);
        set_regs(16'hFFFF, 4'd10);
        run_phase(20);
        set_regs(16'd3, 4'd0);
        run_phase(25);
        set_regs(16'd1, 4'd7);
        run_phase(25);
        set_regs(16'd0, 4'd15);
        run_grab();
        send(read_item());
        send(random_item(dtc_pkg::KIND_SAMPLE));

        settle(8);
        if (n_bad == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hold the item while stalled, then wait out a random gap before the next
    always @(posedge clk) begin : drive_items
        logic              nxt_valid;
        dtc_pkg::t_in_item nxt_data;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nxt_valid = in_valid;
            nxt_data = in_data;
            if (in_valid && !in_stall) begin
                n_taken <= n_taken + 1;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() != 0) begin
                    nxt_data = pending_items.pop_front();
                    nxt_valid = 1'b1;
                    if ($urandom_range(0, 47) == 0)
                        in_steady = !in_steady;
                    in_gap = in_steady ? 0 : $urandom_range(0, 11);
                end
            end
            in_valid <= nxt_valid;
            in_data <= nxt_data;
        end
    end

    // Check each status transfer, then stall for a random number of cycles
    always @(posedge clk) begin : check_status
        dtc_pkg::t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (n_done >= n_taken || status_due.size() == 0) begin
                    $error("status transfer with no item outstanding");
                    n_bad++;
                end else begin
                    want = status_due.pop_front();
                    if (out_data.read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h",
                               want.read_data, out_data.read_data);
                        n_bad++;
                    end
                    if (out_data.mode_now !== want.mode_now) begin
                        $error("mode_now: expected %0d, got %0d",
                               want.mode_now, out_data.mode_now);
                        n_bad++;
                    end
                    if (out_data.current_row !== want.current_row) begin
                        $error("current_row: expected %0d, got %0d",
                               want.current_row, out_data.current_row);
                        n_bad++;
                    end
                    if (out_data.row_count !== want.row_count) begin
                        $error("row_count: expected %0d, got %0d",
                               want.row_count, out_data.row_count);
                        n_bad++;
                    end
                    if (out_data.tick_count !== want.tick_count) begin
                        $error("tick_count: expected %0d, got %0d",
                               want.tick_count, out_data.tick_count);
                        n_bad++;
                    end
                end
                n_done <= n_done + 1;
                if ($urandom_range(0, 47) == 0)
                    out_steady = !out_steady;
                out_hold = out_steady ? 0 : $urandom_range(0, 11);
            end
            if (out_hold > 0) begin
                out_stall <= 1'b1;
                out_hold--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Give up on a hung run
    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
